>>> design/fbsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsb_pkg
// Shared types and the 4b6b code table for the decoder.
// ----------------------------------------------------------------------------
package fbsb_pkg;

   localparam int CODE_WIDTH  = 6;
   localparam int NIBBLE_WIDTH = 4;
   localparam int BYTE_WIDTH  = 8;
   localparam int STORE_WIDTH = 15;
   localparam int COUNT_WIDTH = 4;
   localparam int TABLE_DEPTH = 16;

   typedef logic [STORE_WIDTH-1:0]  store_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [CODE_WIDTH-1:0]   code_type;
   typedef logic [NIBBLE_WIDTH-1:0] nibble_type;
   typedef logic [BYTE_WIDTH-1:0]   byte_type;

   // Store limit: both bit stores hold at most fifteen bits.
   localparam count_type COUNT_MAX = count_type'(STORE_WIDTH);

   // Valid 6-bit codes, listed by their 4-bit data value.
   localparam code_type CODE_TABLE [TABLE_DEPTH] = '{
      6'd21, 6'd49, 6'd50, 6'd35, 6'd52, 6'd37, 6'd38, 6'd22,
      6'd26, 6'd25, 6'd42, 6'd11, 6'd44, 6'd13, 6'd14, 6'd28
   };

   typedef struct packed {
      store_type coded_bits;
      count_type coded_count;
      store_type plain_bits;
      count_type plain_count;
   } state_type;

   typedef struct packed {
      byte_type decoded_byte;
      logic     byte_ready;
      logic     code_error;
   } result_type;

endpackage

>>> design/four_b_six_b_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_b_six_b_decoder_core
// 4b6b line-code decoder: one coded byte in, one result per transaction.
// ----------------------------------------------------------------------------
// Pipeline: the byte lands in the input register at acceptance, and the decode
//   logic loads the result register when that register is free (a stalled
//   response holds the byte in the input register).
// Throughput: 1 transaction per cycle while rsp_stall is low; the bit stores update per step.
// Reset: synchronous, active high; clears both stages' valid flags and the
//   coded and decoded bit stores with their counts.
module four_b_six_b_decoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fbsb_pkg::byte_type  req_encoded_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fbsb_pkg::byte_type  rsp_decoded_byte,
   output logic                rsp_byte_ready,
   output logic                rsp_code_error
);

   // Input register stage.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   fbsb_pkg::byte_type   in_byte_ff;
   fbsb_pkg::byte_type   in_byte_in;

   // Decoder state (coded/decoded bit stores).
   fbsb_pkg::state_type  state_ff;
   fbsb_pkg::state_type  state_in;
   fbsb_pkg::state_type  state_step;

   // Result register stage.
   logic                 out_valid_ff;
   logic                 out_valid_in;
   fbsb_pkg::result_type out_ff;
   fbsb_pkg::result_type out_in;
   fbsb_pkg::result_type step_result;

   logic                 out_free;
   logic                 step_fire;
   logic                 req_take;

   // The result register can load when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   // The held byte moves through the decode logic into the result register.
   assign step_fire = in_valid_ff && out_free;
   // Input register frees up when empty or when its byte moves on.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   fbsb_decode_step u_step (
      .state_cur    (state_ff),
      .encoded_byte (in_byte_ff),
      .state_next   (state_step),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !step_fire);
      in_byte_in   = req_take ? req_encoded_byte : in_byte_ff;
      state_in     = step_fire ? state_step : state_ff;
      out_valid_in = step_fire || (out_valid_ff && rsp_stall);
      out_in       = step_fire ? step_result : out_ff;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_decoded_byte = out_ff.decoded_byte;
   assign rsp_byte_ready   = out_ff.byte_ready;
   assign rsp_code_error   = out_ff.code_error;

`ifndef SYNTH
   // A ready byte is always popped, so fewer than eight decoded bits remain.
   a_plain_below_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff.plain_count < 4'd8)
      else $error("decoded bit count reached a full byte");

   // Without an error every complete code was consumed.
   a_coded_drained: assert property (@(posedge clock) disable iff (reset)
      step_fire && !step_result.code_error |=> state_ff.coded_count < 4'd6)
      else $error("complete code left in store after clean step");

   // No decoded byte value without byte_ready.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.byte_ready |-> out_ff.decoded_byte == '0)
      else $error("decoded byte nonzero without byte_ready");

   // Decoder state moves only when a transaction passes the decode logic.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(state_ff))
      else $error("decoder state changed without a decode step");
`endif

endmodule

>>> design/fbsb_code_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsb_code_lookup
// Reverse lookup of one 6-bit code in the 16-entry code table.
// ----------------------------------------------------------------------------
module fbsb_code_lookup (
   input  fbsb_pkg::code_type   code,
   output logic                 hit,
   output fbsb_pkg::nibble_type index
);

   // Table entries are distinct, so at most one compare matches.
   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int i = 0; i < fbsb_pkg::TABLE_DEPTH; i++) begin
         if (fbsb_pkg::CODE_TABLE[i] == code) begin
            hit   = 1'b1;
            index = fbsb_pkg::nibble_type'(i);
         end
      end
   end

endmodule

>>> design/fbsb_decode_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsb_decode_step
// One byte of decode work: append byte, peel up to two codes, pop a byte.
// ----------------------------------------------------------------------------
module fbsb_decode_step (
   input  fbsb_pkg::state_type  state_cur,
   input  fbsb_pkg::byte_type   encoded_byte,
   output fbsb_pkg::state_type  state_next,
   output fbsb_pkg::result_type result
);

   fbsb_pkg::store_type  coded_app;
   logic [4:0]           coded_sum;
   fbsb_pkg::count_type  coded_cnt1;
   fbsb_pkg::count_type  shift0;
   fbsb_pkg::count_type  shift1;
   fbsb_pkg::code_type   code0;
   fbsb_pkg::code_type   code1;
   logic                 hit0;
   logic                 hit1;
   fbsb_pkg::nibble_type idx0;
   fbsb_pkg::nibble_type idx1;
   logic                 take1;
   logic                 err;
   fbsb_pkg::store_type  plain_app;
   logic [4:0]           plain_sum;
   fbsb_pkg::count_type  plain_cnt;
   logic                 ready;

   // Append the new byte; count saturates at the store size.
   assign coded_app  = {state_cur.coded_bits[fbsb_pkg::STORE_WIDTH-9:0], encoded_byte};
   assign coded_sum  = {1'b0, state_cur.coded_count} + 5'd8;
   assign coded_cnt1 = (coded_sum > {1'b0, fbsb_pkg::COUNT_MAX}) ?
                       fbsb_pkg::COUNT_MAX : coded_sum[3:0];

   // At least eight bits are held now, so the first code is always taken.
   assign shift0 = coded_cnt1 - 4'd6;
   assign code0  = fbsb_pkg::code_type'(coded_app >> shift0);
   assign take1  = hit0 && (shift0 >= 4'd6);
   assign shift1 = shift0 - 4'd6;
   assign code1  = fbsb_pkg::code_type'(coded_app >> shift1);

   fbsb_code_lookup u_lookup0 (.code(code0), .hit(hit0), .index(idx0));
   fbsb_code_lookup u_lookup1 (.code(code1), .hit(hit1), .index(idx1));

   assign err = !hit0 || (take1 && !hit1);

   always_comb begin
      plain_app = state_cur.plain_bits;
      plain_sum = {1'b0, state_cur.plain_count};
      case ({hit0, take1 && hit1})
         2'b10: begin
            plain_app = {state_cur.plain_bits[fbsb_pkg::STORE_WIDTH-5:0], idx0};
            plain_sum = {1'b0, state_cur.plain_count} + 5'd4;
         end
         2'b11: begin
            plain_app = {state_cur.plain_bits[fbsb_pkg::STORE_WIDTH-9:0], idx0, idx1};
            plain_sum = {1'b0, state_cur.plain_count} + 5'd8;
         end
         default: begin
            plain_app = state_cur.plain_bits;
            plain_sum = {1'b0, state_cur.plain_count};
         end
      endcase
   end

   assign plain_cnt = (plain_sum > {1'b0, fbsb_pkg::COUNT_MAX}) ?
                      fbsb_pkg::COUNT_MAX : plain_sum[3:0];
   assign ready     = plain_cnt >= 4'd8;

   always_comb begin
      state_next.coded_bits  = coded_app;
      state_next.coded_count = take1 ? shift1 : shift0;
      state_next.plain_bits  = plain_app;
      state_next.plain_count = ready ? plain_cnt - 4'd8 : plain_cnt;
      result.byte_ready      = ready;
      result.code_error      = err;
      result.decoded_byte    = ready ?
                               fbsb_pkg::byte_type'(plain_app >> (plain_cnt - 4'd8)) : '0;
   end

endmodule

>>> dv/four_b_six_b_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_b_six_b_decoder_checker
// Watches both channels of the 4b6b decoder. Each accepted request transaction
// is decoded by a local copy of the bit stores, and each accepted response
// transaction is compared field by field with the oldest decode still owed.
// ----------------------------------------------------------------------------
module four_b_six_b_decoder_checker
   import fbsb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stall,
   input  byte_type req_encoded_byte,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  byte_type rsp_decoded_byte,
   input  logic     rsp_byte_ready,
   input  logic     rsp_code_error,
   output int       fail_count,
   output int       pending
);

   store_type  coded_store;
   int         coded_held;
   store_type  plain_store;
   int         plain_held;
   result_type owed_decodes[$];

   function automatic int code_index(code_type code);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (CODE_TABLE[i] == code) begin
            return i;
         end
      end
      return -1;
   endfunction

   // One coded byte in: drain whole codes until the store runs short or a
   // code misses the table, then hand out the oldest plain byte if ready.
   task automatic decode_byte(input byte_type coded, output result_type res);
      code_type code;
      int       idx;
      logic     miss;
      res  = '0;
      miss = 1'b0;
      coded_store = {coded_store[STORE_WIDTH-BYTE_WIDTH-1:0], coded};
      coded_held  = (coded_held + BYTE_WIDTH > STORE_WIDTH) ? STORE_WIDTH
                                                            : coded_held + BYTE_WIDTH;
      while (coded_held >= CODE_WIDTH && !miss) begin
         code = code_type'(coded_store >> (coded_held - CODE_WIDTH));
         coded_held -= CODE_WIDTH;
         idx = code_index(code);
         if (idx < 0) begin
            miss = 1'b1;
         end else begin
            plain_store = {plain_store[STORE_WIDTH-NIBBLE_WIDTH-1:0], nibble_type'(idx)};
            plain_held  = (plain_held + NIBBLE_WIDTH > STORE_WIDTH) ? STORE_WIDTH
                                                                    : plain_held + NIBBLE_WIDTH;
         end
      end
      if (plain_held >= BYTE_WIDTH) begin
         res.decoded_byte = byte_type'(plain_store >> (plain_held - BYTE_WIDTH));
         res.byte_ready   = 1'b1;
         plain_held      -= BYTE_WIDTH;
      end
      res.code_error = miss;
   endtask

   // Responses are scored before this edge's request is booked, so a
   // response can never match a decode owed from the same edge.
   always @(posedge clock) begin
      result_type res;
      result_type owed;
      if (reset) begin
         coded_store = '0;
         coded_held  = 0;
         plain_store = '0;
         plain_held  = 0;
         owed_decodes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_decodes.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               owed = owed_decodes.pop_front();
               if (rsp_decoded_byte !== owed.decoded_byte) begin
                  $error("decoded_byte: expected %0h, got %0h",
                         owed.decoded_byte, rsp_decoded_byte);
                  fail_count++;
               end
               if (rsp_byte_ready !== owed.byte_ready) begin
                  $error("byte_ready: expected %0b, got %0b",
                         owed.byte_ready, rsp_byte_ready);
                  fail_count++;
               end
               if (rsp_code_error !== owed.code_error) begin
                  $error("code_error: expected %0b, got %0b",
                         owed.code_error, rsp_code_error);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_encoded_byte, res);
            owed_decodes.push_back(res);
         end
      end
      pending = owed_decodes.size();
   end

endmodule

>>> dv/four_b_six_b_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_b_six_b_decoder_core_test
// Drives coded bytes into the 4b6b decoder and lets the checker score every
// response. Stimulus is mostly well-formed code streams with sparse bad
// codes, plus noise bursts that knock the decoder off its code grid; each
// burst is followed by a flush and sync pattern that puts it back on grid.
// ----------------------------------------------------------------------------
module four_b_six_b_decoder_core_test;
   import fbsb_pkg::*;

   // Stream shaping
   localparam int TOTAL_ITEMS   = 1425;
   localparam int IDLE_PERCENT  = 21;
   localparam int NOISE_PERCENT = 15;
   localparam int BAD_PERCENT   = 4;
   // Bad codes at least this many codes apart never pile up in the coded
   // store, so a well-formed stream keeps its alignment across them.
   localparam int BAD_SPACING   = 6;
   // Window of transactions with no idling on either side.
   localparam int STEADY_FIRST  = 600;
   localparam int STEADY_LAST   = 800;

   // Resync pattern. Eight all-ones bytes leave the coded store full of ones
   // with nine bits held, whatever came before (111111 is not a code). The
   // lead byte then forces one more miss; lead and tail together decode as
   // codes 21 and 49 and leave 3'b010 held, the head of code 21, whose tail
   // 3'b101 opens the next well-formed stream.
   localparam int       FLUSH_BYTES   = 8;
   localparam byte_type FLUSH_BYTE    = 8'hFF;
   localparam byte_type SYNC_LEAD     = 8'hAB;
   localparam byte_type SYNC_TAIL     = 8'h8A;
   localparam int       SYNC_REST     = 3'b101;
   localparam int       SYNC_REST_LEN = 3;
   localparam code_type ALL_ONES_CODE = 6'b111111;
   localparam code_type ALL_ZERO_CODE = 6'b000000;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   byte_type req_encoded_byte;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   byte_type rsp_decoded_byte;
   logic     rsp_byte_ready;
   logic     rsp_code_error;

   int          fail_count;
   int          pending;
   int          sent_count = 0;
   logic        steady = 1'b0;
   logic [31:0] stream_bits = '0;   // coded bits waiting to fill a byte
   int          stream_held = 0;
   int          since_bad = 0;

   four_b_six_b_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_encoded_byte (req_encoded_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_byte_ready   (rsp_byte_ready),
      .rsp_code_error   (rsp_code_error)
   );

   four_b_six_b_decoder_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_encoded_byte (req_encoded_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_byte_ready   (rsp_byte_ready),
      .rsp_code_error   (rsp_code_error),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure, off during the steady window.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // One request transaction: optional idle cycles, then hold the byte until
   // the block takes it. Returns in the step of acceptance with no pending
   // assignment to req_valid, so the caller may drive it again.
   task automatic send_byte(input byte_type coded);
      steady = (sent_count >= STEADY_FIRST) && (sent_count < STEADY_LAST);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_encoded_byte <= coded;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Append one 6-bit code to the stream, sending every byte it completes.
   task automatic push_code(input code_type code);
      stream_bits = (stream_bits << CODE_WIDTH) | code;
      stream_held += CODE_WIDTH;
      while (stream_held >= BYTE_WIDTH) begin
         send_byte(byte_type'(stream_bits >> (stream_held - BYTE_WIDTH)));
         stream_held -= BYTE_WIDTH;
      end
   endtask

   // Close out a partial byte with zero fill.
   task automatic pad_out();
      if (stream_held > 0) begin
         send_byte(byte_type'(stream_bits << (BYTE_WIDTH - stream_held)));
         stream_held = 0;
      end
   endtask

   // Flush the coded store with ones (overflow included), then realign.
   task automatic resync();
      pad_out();
      repeat (FLUSH_BYTES) send_byte(FLUSH_BYTE);
      send_byte(SYNC_LEAD);
      send_byte(SYNC_TAIL);
      stream_bits = SYNC_REST;
      stream_held = SYNC_REST_LEN;
      since_bad   = 0;
   endtask

   initial begin
      code_type bad_code;
      logic     hit;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_encoded_byte <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every table code in order from the empty store (the first
      // byte delivers no plain byte), then two codes that miss the table,
      // an all-zero byte, and the all-ones flush that overflows the store.
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         push_code(CODE_TABLE[n]);
      end
      push_code(ALL_ONES_CODE);
      push_code(ALL_ZERO_CODE);
      pad_out();
      send_byte(8'h00);
      resync();

      // Random: mostly well-formed streams with sparse bad codes; now and then
      // a noise burst (random bytes and zero runs) followed by a resync.
      while (sent_count < TOTAL_ITEMS) begin
         if ($urandom_range(0, 99) < NOISE_PERCENT) begin
            pad_out();
            repeat ($urandom_range(3, 20)) begin
               send_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                     : byte_type'($urandom_range(0, 255)));
            end
            resync();
         end else begin
            repeat ($urandom_range(12, 80)) begin
               if (since_bad >= BAD_SPACING && $urandom_range(0, 99) < BAD_PERCENT) begin
                  do begin
                     bad_code = code_type'($urandom_range(0, 63));
                     hit = 1'b0;
                     for (int n = 0; n < TABLE_DEPTH; n++) begin
                        if (CODE_TABLE[n] == bad_code) begin
                           hit = 1'b1;
                        end
                     end
                  end while (hit);
                  push_code(bad_code);
                  since_bad = 0;
               end else begin
                  push_code(CODE_TABLE[$urandom_range(0, TABLE_DEPTH - 1)]);
                  since_bad++;
               end
            end
         end
      end
      req_valid <= 1'b0;

      // Drain: let the last transaction be booked, wait for every owed response,
      // then keep clocking to catch strays.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("four_b_six_b_decoder_core_test: done, clean");
      end else begin
         $display("four_b_six_b_decoder_core_test: done, errors");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("four_b_six_b_decoder_core_test: done, errors");
      $finish;
   end

endmodule
